### rtl/rst_pkg.sv
// Package: shared types and constants for the relocation stack tracker.
`timescale 1ns / 1ps
package rst_pkg;
    typedef enum logic [1:0] {
        MODE_CLEAR    = 2'd0,
        MODE_LOAD     = 2'd1,
        MODE_RELOCATE = 2'd2,
        MODE_RETRIEVE = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_SRC,
        ST_WAIT_SRC,
        ST_RD_DST,
        ST_WAIT_DST,
        ST_WR_DST,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_RES_RD,
        ST_RES_WAIT,
        ST_OUT
    } t_state;

    localparam logic [15:0] MAX_PRIO_RESET = 16'd65534;
    localparam int          SLOT_W         = 16 + 16 + 4 + 16;
    localparam int          ADDR_CFG_MAXP  = 0;

    // Ground run-minimum: max_priority plus one, saturated.
    function automatic logic [15:0] ground_value(input logic [15:0] maxp);
        ground_value = (maxp == 16'hFFFF) ? 16'hFFFF : maxp + 16'd1;
    endfunction
endpackage

### rtl/rst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module rst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/relocation_stack_tracker.sv
// Top level: relocation stack tracker with slot memory and scan sequencer.
`timescale 1ns / 1ps
// Relocation stack tracker.
// Input channel (s_axis_*): one item per operation; tdata carries mode,
// source stack, destination stack, priority and step label. Output channel
// (m_axis_*): one result item per input item, carrying retrievable, bad
// count, block count, target stack, target priority and error.
// Slot contents (priority, running minimum, above count, label) live in one
// synchronous RAM of STACKS*TIERS entries with one registered read port.
// Heights and change steps sit in flip-flops.
// Clear and refused items go straight to the result read; relocate skips
// the destination read when the destination is empty; load and retrieve
// rescan the top slot of every stack through the RAM port, with a read
// state and a compare state per stack. One item is in work at a time;
// s_axis_tready is high only in idle, so a new item is not taken until
// the last one has been passed to the output register.
// Reset (synchronous, active low) empties all stacks, clears the counts,
// sets the target to -1 and max_priority to 65534; slot RAM needs no clear
// since a slot is only read below a stack's height.
// When the receiver stalls, the result is held in the output register; the
// next item is still taken and worked, then waits in its last state until
// the output register frees up, and input stalls meanwhile.
// Register 0 (byte address 0): max_priority, 16 bits.
module relocation_stack_tracker
    import rst_pkg::*;
#(
    parameter int STACKS = 16,
    parameter int TIERS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] mode, [5:2] source_stack, [9:6] dest_stack,
    // [25:10] priority_req, [41:26] step_label, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] retrievable, [8:1] bad_count, [16:9] blocks_left,
    // [21:17] target_stack, [37:22] target_priority, [38] error, [39] zero
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SW = $clog2(STACKS);
    localparam int TW = $clog2(TIERS);
    localparam int HW = $clog2(TIERS + 1);
    localparam int AW = $clog2(STACKS * TIERS);

    // Configuration
    logic [15:0] r_maxp;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'(ADDR_CFG_MAXP * 4)) ? {16'd0, r_maxp} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_maxp <= MAX_PRIO_RESET;
        else if (psel && penable && pwrite && paddr == 2'(ADDR_CFG_MAXP * 4))
            r_maxp <= pwdata[15:0];
    end
    logic [15:0] w_ground;
    assign w_ground = ground_value(r_maxp);

    // Per-stack heights and change steps
    logic [HW-1:0] r_height [STACKS];
    logic [15:0]   r_chg    [STACKS];

    // Item latch
    logic [1:0]  r_mode;
    logic [3:0]  r_src, r_dst;
    logic [15:0] r_prio, r_lbl;

    // Working registers
    t_state      r_state, n_state;
    logic [7:0]  r_blocks, r_bad;
    logic signed [4:0] r_min;
    logic        r_err;
    logic [15:0] r_mvprio;     // priority moved or loaded
    logic [15:0] r_bmin;       // below-slot run min
    logic [3:0]  r_babove;
    logic [SW-1:0] r_scan;
    logic [SW-1:0] r_best;
    logic [15:0] r_bestv;
    logic        r_scan_last;

    // Result: r_res is the finished payload, r_odata the output register
    logic        r_ovalid;
    logic [39:0] r_odata;
    logic [39:0] r_res;
    logic        w_out_free;

    // RAM
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [SLOT_W-1:0] w_wdata, w_rdata;
    rst_ram #(.WIDTH(SLOT_W), .DEPTH(STACKS * TIERS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    // slot word: [51:36] priority, [35:20] run min, [19:16] above, [15:0] label
    logic [15:0] w_rd_prio, w_rd_min;
    logic [3:0]  w_rd_above;
    assign w_rd_prio  = w_rdata[51:36];
    assign w_rd_min   = w_rdata[35:20];
    assign w_rd_above = w_rdata[19:16];

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                                input logic [HW-1:0] h);
        logic [HW-1:0] t;
        t = h - HW'(1);
        slot_addr = AW'(s) * AW'(TIERS) + AW'(t[(TW > 0 ? TW-1 : 0):0]);
    endfunction

    logic          s_src_ok, s_dst_ok;
    logic [SW-1:0] w_src, w_dst, w_mins;
    logic [HW-1:0] w_hsrc, w_hdst, w_hscan, w_hmin;
    assign s_src_ok = 32'(r_src) < 32'(STACKS);
    assign s_dst_ok = 32'(r_dst) < 32'(STACKS);
    assign w_src    = SW'(r_src);
    assign w_dst    = SW'(r_dst);
    assign w_mins   = SW'(r_min[3:0]);
    assign w_hsrc   = r_height[w_src];
    assign w_hdst   = r_height[w_dst];
    assign w_hscan  = r_height[r_scan];
    assign w_hmin   = r_height[w_mins];

    // Destination stack for the push (load pushes onto source)
    logic [SW-1:0] w_push_s;
    logic [HW-1:0] w_push_h; // height before push, after any pop
    assign w_push_s = (r_mode == MODE_LOAD) ? w_src : w_dst;
    // While the pop is still pending, a move onto the same stack sees one less
    assign w_push_h = (r_state == ST_WAIT_SRC && r_mode == MODE_RELOCATE &&
                       w_src == w_dst) ? w_hsrc - HW'(1) : r_height[w_push_s];

    // New slot contents
    logic        w_le;
    logic [15:0] w_nmin;
    logic [3:0]  w_nabove;
    assign w_le     = r_mvprio <= r_bmin;
    assign w_nmin   = w_le ? r_mvprio : r_bmin;
    assign w_nabove = w_le ? 4'd0 : (r_babove == 4'd15 ? 4'd15 : r_babove + 4'd1);

    logic s_accept;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (s_accept) n_state = ST_CHECK;
            ST_CHECK: begin
                unique case (t_mode'(r_mode))
                    MODE_CLEAR: n_state = ST_RES_RD;
                    MODE_LOAD:
                        n_state = (!s_src_ok || w_hsrc >= HW'(TIERS)) ? ST_RES_RD :
                                  (w_hsrc == '0 ? ST_WR_DST : ST_RD_DST);
                    MODE_RELOCATE:
                        n_state = (!s_src_ok || !s_dst_ok || w_hsrc == '0 ||
                                   (w_src != w_dst && w_hdst >= HW'(TIERS))) ?
                                  ST_RES_RD : ST_RD_SRC;
                    MODE_RETRIEVE:
                        n_state = (r_blocks == 8'd0 || r_min < 0 ||
                                   32'(r_min[3:0]) >= 32'(STACKS) || w_hmin == '0) ?
                                  ST_RES_RD : ST_RD_SRC;
                    default: n_state = ST_RES_RD;
                endcase
            end
            ST_RD_SRC:   n_state = ST_WAIT_SRC;
            ST_WAIT_SRC: n_state = (r_mode == MODE_RETRIEVE) ? ST_SCAN_RD :
                                   (w_push_h == '0 ? ST_WR_DST : ST_RD_DST);
            ST_RD_DST:   n_state = ST_WAIT_DST;
            ST_WAIT_DST: n_state = ST_WR_DST;
            ST_WR_DST:   n_state = (r_mode == MODE_LOAD) ? ST_SCAN_RD : ST_RES_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: n_state = r_scan_last ? ST_RES_RD : ST_SCAN_RD;
            ST_RES_RD:   n_state = ST_RES_WAIT;
            ST_RES_WAIT: n_state = ST_OUT;
            ST_OUT:      n_state = w_out_free ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    // RAM control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = slot_addr(w_push_s, w_push_h + HW'(1));
        w_wdata = {r_mvprio, w_nmin, w_nabove,
                   (r_mode == MODE_LOAD) ? 16'd0 : r_lbl};
        w_raddr = '0;
        unique case (r_state)
            ST_RD_SRC:  w_raddr = (r_mode == MODE_RETRIEVE) ? slot_addr(w_mins, w_hmin)
                                                           : slot_addr(w_src, w_hsrc);
            ST_RD_DST:  w_raddr = slot_addr(w_push_s, w_push_h);
            ST_WR_DST:  w_we = 1'b1;
            ST_SCAN_RD: w_raddr = slot_addr(r_scan, w_hscan);
            ST_RES_RD:  w_raddr = slot_addr(w_mins, w_hmin);
            default: ;
        endcase
    end

    logic [15:0] w_scan_v;
    assign w_scan_v = (w_hscan == '0) ? w_ground : w_rd_min;

    logic        w_has;
    logic [15:0] w_res_min;
    logic        w_res_ret;
    assign w_has     = r_blocks != 8'd0 && !r_min[4];
    assign w_res_min = (w_hmin == '0) ? w_ground : w_rd_min;
    assign w_res_ret = w_has && (w_hmin == '0 || w_rd_above == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_blocks <= '0;
            r_bad    <= '0;
            r_min    <= -5'sd1;
            r_ovalid <= 1'b0;
            r_err    <= 1'b0;
            for (int i = 0; i < STACKS; i++) begin
                r_height[i] <= '0;
                r_chg[i]    <= '0;
            end
        end else begin
            r_state <= n_state;
            // Output register loads when free or being emptied this cycle
            if (r_state == ST_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (s_accept) begin
                    r_mode <= s_axis_tdata[1:0];
                    r_src  <= s_axis_tdata[5:2];
                    r_dst  <= s_axis_tdata[9:6];
                    r_prio <= s_axis_tdata[25:10];
                    r_lbl  <= s_axis_tdata[41:26];
                    r_err  <= 1'b0;
                end
                ST_CHECK: begin
                    r_scan <= '0;
                    r_scan_last <= (STACKS == 1);
                    r_mvprio <= r_prio;
                    r_bmin   <= w_ground;
                    r_babove <= 4'd0;
                    if (n_state == ST_RES_RD && r_mode != MODE_CLEAR) r_err <= 1'b1;
                    if (r_mode == MODE_CLEAR) begin
                        r_blocks <= '0;
                        r_bad    <= '0;
                        r_min    <= -5'sd1;
                        for (int i = 0; i < STACKS; i++) begin
                            r_height[i] <= '0;
                            r_chg[i]    <= '0;
                        end
                    end
                end
                ST_WAIT_SRC: begin
                    if (w_rd_above != 4'd0) r_bad <= r_bad - 8'd1;
                    if (r_mode == MODE_RETRIEVE) begin
                        r_height[w_mins] <= w_hmin - HW'(1);
                        r_chg[w_mins]    <= r_lbl;
                        r_blocks         <= r_blocks - 8'd1;
                    end else begin
                        r_height[w_src] <= w_hsrc - HW'(1);
                        r_chg[w_src]    <= r_lbl;
                        r_mvprio        <= w_rd_prio;
                    end
                end
                ST_WAIT_DST: begin
                    r_bmin   <= w_rd_min;
                    r_babove <= w_rd_above;
                end
                ST_WR_DST: begin
                    r_height[w_push_s] <= w_push_h + HW'(1);
                    if (!w_le) r_bad <= r_bad + 8'd1;
                    if (r_mode == MODE_LOAD) r_blocks <= r_blocks + 8'd1;
                    else r_chg[w_push_s] <= r_lbl;
                end
                ST_SCAN_CMP: begin
                    if (r_scan == '0 || w_scan_v < r_bestv) begin
                        r_best  <= r_scan;
                        r_bestv <= w_scan_v;
                    end
                    r_scan      <= r_scan + SW'(1);
                    r_scan_last <= (32'(r_scan) + 32'd2 >= 32'(STACKS));
                    if (r_scan_last) begin
                        if (r_blocks == 8'd0) r_min <= -5'sd1;
                        else if (r_scan == '0 || w_scan_v < r_bestv)
                            r_min <= 5'(r_scan);
                        else r_min <= 5'(r_best);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result payload, captured when the target slot read returns
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RES_WAIT)
            r_res <= {1'b0, r_err, (r_min[4] ? 16'd0 : w_res_min), r_min,
                      r_blocks, r_bad, w_res_ret};
        if (r_state == ST_OUT && w_out_free)
            r_odata <= r_res;
    end
endmodule
